@@ src/bls_pkg.sv @@
// Package for the breathing LED sequencer: phase codes, register indexes,
// reset values, arithmetic constants, the gamma ROM and the shared structs.
// No dependencies; every module of the block imports it.
package bls_pkg;

    // Width of the hold counter.
    localparam int WAIT_W = 16;
    // Width used to compare the counter against a hold length.
    localparam int CMP_W  = (WAIT_W + 1 > 16) ? WAIT_W + 1 : 16;

    localparam int LEVEL_W   = 7;
    localparam int GAMMA_W   = 7;
    localparam int REM_W     = 7;
    localparam int QUOT_W    = 26;
    localparam int PERIOD_W  = 32;
    localparam int HOLD_W    = 16;
    localparam int LED_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int RPROD_W   = REM_W + GAMMA_W;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 7'd0;

    // Status LED patterns (active low on the pins).
    localparam logic [LED_W-1:0] LED_ALL = 4'hF;
    localparam logic [LED_W-1:0] LED_ONE = 4'h1;
    localparam logic [LED_W-1:0] LED_TWO = 4'h3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_HOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_PAUSE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_PAUSE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD   = 2'd3;

    // Reset values of the registers and of the derived quotient/remainder.
    localparam logic [HOLD_W-1:0]   RAMP_HOLD_RST    = 16'd15;
    localparam logic [HOLD_W-1:0]   PEAK_PAUSE_RST   = 16'd100;
    localparam logic [HOLD_W-1:0]   BOTTOM_PAUSE_RST = 16'd300;
    localparam logic [PERIOD_W-1:0] PERIOD_RST       = 32'd72000;
    localparam logic [QUOT_W-1:0]   QUOT_RST         = 26'd720;
    localparam logic [REM_W-1:0]    REM_RST          = 7'd0;

    // Exact unsigned 32-bit divide by 100: (x * DIV100_MAGIC) >> 37.
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
    localparam int          DIV100_SHIFT = 37;
    localparam logic [31:0] HUNDRED      = 32'd100;

    // Small divide by 100 for values below 9901: (x * 5243) >> 19.
    localparam int             RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP100 = 13'd5243;
    localparam int             RECIP_SHIFT = 19;
    localparam int             RDIV_W      = 8;

    typedef enum logic [1:0] {
        PH_RAMP_UP   = 2'd0,
        PH_PEAK      = 2'd1,
        PH_RAMP_DOWN = 2'd2,
        PH_BOTTOM    = 2'd3
    } t_phase;

    // Sequencer state as seen after a transaction.
    typedef struct packed {
        t_phase             phase;
        logic [LEVEL_W-1:0] level;
    } t_state;

    // Register values handed from the configuration block.
    typedef struct packed {
        logic [HOLD_W-1:0] ramp_hold;
        logic [HOLD_W-1:0] peak_pause;
        logic [HOLD_W-1:0] bottom_pause;
        logic [QUOT_W-1:0] quot;
        logic [REM_W-1:0]  rem;
    } t_cfg;

    localparam logic [7:0] GAMMA_ROM [0:100] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd3,
        8'd3,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd8,
        8'd8,   8'd9,   8'd10,  8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,
        8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd24,  8'd25,  8'd26,  8'd28,
        8'd29,  8'd31,  8'd32,  8'd34,  8'd36,  8'd37,  8'd39,  8'd41,  8'd43,  8'd45,
        8'd47,  8'd49,  8'd51,  8'd53,  8'd55,  8'd58,  8'd60,  8'd62,  8'd65,  8'd67,
        8'd70,  8'd73,  8'd75,  8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,
        8'd100, 8'd103, 8'd106, 8'd110, 8'd113, 8'd117, 8'd121, 8'd124, 8'd128, 8'd132,
        8'd136, 8'd140, 8'd144, 8'd148, 8'd152, 8'd156, 8'd161, 8'd165, 8'd170, 8'd174,
        8'd179
    };

    // Gamma-corrected level, clamped to the top of the linear scale.
    function automatic logic [GAMMA_W-1:0] gamma_clamped(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] idx;
        logic [7:0]         raw;
        idx = (level > LEVEL_TOP) ? LEVEL_TOP : level;
        raw = GAMMA_ROM[idx];
        if (raw > {1'b0, LEVEL_TOP}) begin
            return LEVEL_TOP;
        end
        return raw[GAMMA_W-1:0];
    endfunction

endpackage

@@ src/bls_tick_if.sv @@
// Input channel of the breathing LED sequencer: valid/ready plus the tick bit.
// No dependencies.
interface bls_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

@@ src/bls_res_if.sv @@
// Result channel of the breathing LED sequencer: valid/ready plus the result fields.
// No dependencies.
interface bls_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] compare_value;
    logic [6:0]  linear_level;
    logic [1:0]  phase;
    logic [3:0]  status_leds;

    modport source (output valid, output compare_value, output linear_level,
                    output phase, output status_leds, input ready);
    modport sink   (input valid, input compare_value, input linear_level,
                    input phase, input status_leds, output ready);
endinterface

@@ src/bls_cfg_regs.sv @@
// Configuration registers of the sequencer, plus the PWM period split into
// quotient and remainder by 100 for the scaling pipeline. Uses bls_pkg.
module bls_cfg_regs
    import bls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [HOLD_W-1:0]   r_ramp_hold;
    logic [HOLD_W-1:0]   r_peak_pause;
    logic [HOLD_W-1:0]   r_bottom_pause;
    logic [PERIOD_W-1:0] r_period;
    logic [QUOT_W-1:0]   r_quot;
    logic [REM_W-1:0]    r_rem;
    logic [63:0]         w_quot_prod;
    logic [PERIOD_W-1:0] w_rem_full;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_hold    <= RAMP_HOLD_RST;
            r_peak_pause   <= PEAK_PAUSE_RST;
            r_bottom_pause <= BOTTOM_PAUSE_RST;
            r_period       <= PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RAMP_HOLD:    r_ramp_hold    <= i_cfg_data[HOLD_W-1:0];
                CFG_PEAK_PAUSE:   r_peak_pause   <= i_cfg_data[HOLD_W-1:0];
                CFG_BOTTOM_PAUSE: r_bottom_pause <= i_cfg_data[HOLD_W-1:0];
                CFG_PWM_PERIOD:   r_period       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Quotient by reciprocal multiply; the remainder follows in the next cycle from the registered quotient.
    assign w_quot_prod = 64'(r_period) * 64'(DIV100_MAGIC);
    assign w_rem_full  = r_period - (32'(r_quot) * HUNDRED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quot <= QUOT_RST;
            r_rem  <= REM_RST;
        end else begin
            r_quot <= w_quot_prod[DIV100_SHIFT+QUOT_W-1:DIV100_SHIFT];
            r_rem  <= w_rem_full[REM_W-1:0];
        end
    end

    assign o_cfg.ramp_hold    = r_ramp_hold;
    assign o_cfg.peak_pause   = r_peak_pause;
    assign o_cfg.bottom_pause = r_bottom_pause;
    assign o_cfg.quot         = r_quot;
    assign o_cfg.rem          = r_rem;

endmodule

@@ src/bls_phase_ctrl.sv @@
// Breathing phase sequencer: phase, linear level and hold counter, advanced
// once per accepted tick. Uses bls_pkg.
module bls_phase_ctrl
    import bls_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  t_cfg   i_cfg,
    output t_state o_next
);

    t_phase             r_phase;
    t_phase             n_phase;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;
    logic [WAIT_W-1:0]  r_wait;
    logic [WAIT_W-1:0]  n_wait;
    logic [HOLD_W-1:0]  w_limit;
    logic [WAIT_W:0]    w_wait_inc;
    logic               w_hold_end;

    // Hold length of the current phase and end-of-hold detection.
    always_comb begin
        unique case (r_phase)
            PH_PEAK:   w_limit = i_cfg.peak_pause;
            PH_BOTTOM: w_limit = i_cfg.bottom_pause;
            default:   w_limit = i_cfg.ramp_hold;
        endcase
        w_wait_inc = {1'b0, r_wait} + {{WAIT_W{1'b0}}, 1'b1};
        w_hold_end = w_wait_inc[WAIT_W] || (CMP_W'(w_wait_inc) >= CMP_W'(w_limit));
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_adv && w_hold_end) begin
            unique case (r_phase)
                PH_RAMP_UP: begin
                    if (r_level >= LEVEL_TOP) begin
                        n_phase = PH_PEAK;
                    end
                end
                PH_PEAK:      n_phase = PH_RAMP_DOWN;
                PH_RAMP_DOWN: begin
                    if (r_level == LEVEL_ZERO) begin
                        n_phase = PH_BOTTOM;
                    end
                end
                PH_BOTTOM:    n_phase = PH_RAMP_UP;
                default:      n_phase = PH_RAMP_UP;
            endcase
        end
    end

    // Level and hold counter.
    always_comb begin
        n_level = r_level;
        n_wait  = r_wait;
        if (i_adv) begin
            if (!w_hold_end) begin
                n_wait = w_wait_inc[WAIT_W-1:0];
            end else begin
                n_wait = '0;
                unique case (r_phase)
                    PH_RAMP_UP: begin
                        if (r_level < LEVEL_TOP) begin
                            n_level = r_level + 7'd1;
                        end
                    end
                    PH_PEAK:      n_level = LEVEL_TOP;
                    PH_RAMP_DOWN: begin
                        if (r_level != LEVEL_ZERO) begin
                            n_level = r_level - 7'd1;
                        end
                    end
                    PH_BOTTOM:    n_level = LEVEL_ZERO;
                    default:      n_level = LEVEL_ZERO;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RAMP_UP;
            r_level <= LEVEL_ZERO;
            r_wait  <= '0;
        end else begin
            r_phase <= n_phase;
            r_level <= n_level;
            r_wait  <= n_wait;
        end
    end

    // The pipeline captures the state as it stands after this transaction.
    assign o_next.phase = n_phase;
    assign o_next.level = n_level;

    a_peak_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PEAK |-> r_level == LEVEL_TOP)
        else $error("peak phase with level below the top");

    a_bottom_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BOTTOM |-> r_level == LEVEL_ZERO)
        else $error("bottom rest with nonzero level");

    a_hold_without_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_phase) && $stable(r_level) && $stable(r_wait))
        else $error("sequencer state moved without a tick");

endmodule

@@ src/bls_scale_pipe.sv @@
// Four-stage scaling pipeline: gamma lookup, quotient product, remainder
// product, then the compare value and status LEDs. Uses bls_pkg.
module bls_scale_pipe
    import bls_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_state              i_next,
    input  t_cfg                i_cfg,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_valid,
    output logic [PERIOD_W-1:0] o_compare_value,
    output logic [LEVEL_W-1:0]  o_linear_level,
    output logic [1:0]          o_phase,
    output logic [LED_W-1:0]    o_status_leds
);

    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_rdy4;

    logic                r_v1;
    logic [GAMMA_W-1:0]  r_g1;
    t_state              r_s1;
    logic                r_v2;
    logic [GAMMA_W-1:0]  r_g2;
    logic [PERIOD_W-1:0] r_qg2;
    t_state              r_s2;
    logic                r_v3;
    logic [RPROD_W-1:0]  r_rg3;
    logic [PERIOD_W-1:0] r_qg3;
    t_state              r_s3;
    logic                r_v4;
    logic [PERIOD_W-1:0] r_cmp4;
    t_state              r_s4;

    logic [QUOT_W+GAMMA_W-1:0]  w_qg;
    logic [RPROD_W+RECIP_W-1:0] w_rdiv_prod;
    logic [RDIV_W-1:0]          w_rdiv;
    logic [LED_W-1:0]           w_pattern;

    // A stage takes new data when it is empty or its contents move on.
    assign w_rdy4     = !r_v4 || i_out_ready;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_load;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage 1: gamma lookup on the new level.
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_g1 <= gamma_clamped(i_next.level);
            r_s1 <= i_next;
        end
    end

    // Stage 2: quotient of period/100 times gamma.
    assign w_qg = (QUOT_W+GAMMA_W)'(i_cfg.quot) * (QUOT_W+GAMMA_W)'(r_g1);

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_qg2 <= w_qg[PERIOD_W-1:0];
            r_g2  <= r_g1;
            r_s2  <= r_s1;
        end
    end

    // Stage 3: remainder of period/100 times gamma.
    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_rg3 <= RPROD_W'(i_cfg.rem) * RPROD_W'(r_g2);
            r_qg3 <= r_qg2;
            r_s3  <= r_s2;
        end
    end

    // Stage 4: floor(rem*gamma/100) added to the quotient product.
    assign w_rdiv_prod = (RPROD_W+RECIP_W)'(r_rg3) * (RPROD_W+RECIP_W)'(RECIP100);
    assign w_rdiv      = w_rdiv_prod[RECIP_SHIFT+RDIV_W-1:RECIP_SHIFT];

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_cmp4 <= r_qg3 + PERIOD_W'(w_rdiv);
            r_s4   <= r_s3;
        end
    end

    // Two LEDs lit while the level is high or falling, one otherwise.
    always_comb begin
        unique case (r_s4.phase)
            PH_PEAK, PH_RAMP_DOWN: w_pattern = LED_TWO;
            default:               w_pattern = LED_ONE;
        endcase
    end

    assign o_valid         = r_v4;
    assign o_compare_value = r_cmp4;
    assign o_linear_level  = r_s4.level;
    assign o_phase         = r_s4.phase;
    assign o_status_leds   = LED_ALL & ~w_pattern;

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_v1 && r_v2 && r_v3 && r_v4 && !i_out_ready)
        else $error("input blocked while the pipeline has room");

endmodule

@@ src/breathing_led_sequencer.sv @@
// Breathing LED sequencer top level: configuration port, tick and result channels.
// Depends on bls_pkg, bls_tick_if, bls_res_if, bls_cfg_regs, bls_phase_ctrl,
// bls_scale_pipe.
//
// Usage: each transaction on the tick channel carries one bit. A tick of 1
// advances the four-phase breathing cycle (ramp up, peak, ramp down, bottom)
// and a tick of 0 only reports. Every input transaction yields
// exactly one result transaction with the PWM compare value, the linear level,
// the phase and the active-low status LED pattern after the update.
// Each result is registered through the four stages of the scaling pipeline;
// one transaction per cycle is sustained while the receiver is ready.
// When the receiver stalls, results collect in the pipeline and input is still
// accepted until four transactions are in flight.
// The configuration port writes one register per cycle with i_cfg_we; the
// period quotient is registered from the period, the remainder from the quotient.
// Reset (synchronous, active low) empties the pipeline, starts at ramp up with
// level zero, and loads ramp hold 15, peak pause 100, bottom pause 300 and
// a PWM period of 72000 counts.
module breathing_led_sequencer
    import bls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    bls_tick_if.sink             i_tick_chan,
    bls_res_if.source            o_res_chan
);

    t_cfg   w_cfg;
    t_state w_next;
    logic   w_in_ready;
    logic   w_accept;

    assign w_accept          = i_tick_chan.valid && w_in_ready;
    assign i_tick_chan.ready = w_in_ready;

    bls_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bls_phase_ctrl u_phase_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_accept && i_tick_chan.tick),
        .i_cfg   (w_cfg),
        .o_next  (w_next)
    );

    bls_scale_pipe u_scale_pipe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_accept),
        .i_next          (w_next),
        .i_cfg           (w_cfg),
        .i_out_ready     (o_res_chan.ready),
        .o_in_ready      (w_in_ready),
        .o_valid         (o_res_chan.valid),
        .o_compare_value (o_res_chan.compare_value),
        .o_linear_level  (o_res_chan.linear_level),
        .o_phase         (o_res_chan.phase),
        .o_status_leds   (o_res_chan.status_leds)
    );

endmodule
